>>> rtl/cred_pkg.sv
// ----------------------------------------------------------------------------
// cred_pkg
// shared types and constants for the credential set and permission check
// ----------------------------------------------------------------------------
package cred_pkg;

    localparam int unsigned ID_W     = 32;
    localparam int unsigned REQ_W    = 3;
    localparam int unsigned MODE_W   = 9;
    localparam int unsigned ACCESS_W = 3;

    localparam int unsigned MODE_OWNER_LSB = 6;
    localparam int unsigned MODE_GROUP_LSB = 3;
    localparam int unsigned MODE_OTHER_LSB = 0;

    localparam logic [ID_W-1:0] ROOT_ID = '0;

    typedef enum logic [REQ_W-1:0] {
        REQ_INIT    = 3'd0,
        REQ_SETUID  = 3'd1,
        REQ_SETEUID = 3'd2,
        REQ_SETGID  = 3'd3,
        REQ_SETEGID = 3'd4,
        REQ_CHECK   = 3'd5
    } t_req_type;

    typedef struct packed {
        logic [REQ_W-1:0]    req_type;
        logic [ID_W-1:0]     id_user;
        logic [ID_W-1:0]     id_group;
        logic [MODE_W-1:0]   perm_mode;
        logic [ACCESS_W-1:0] want_access;
    } t_req;

endpackage

>>> rtl/cred_req_if.sv
// ----------------------------------------------------------------------------
// cred_req_if
// request channel: valid/ready handshake with the request fields
// ----------------------------------------------------------------------------
interface cred_req_if;
    import cred_pkg::*;

    logic                valid;
    logic                ready;
    logic [REQ_W-1:0]    req_type;
    logic [ID_W-1:0]     id_user;
    logic [ID_W-1:0]     id_group;
    logic [MODE_W-1:0]   perm_mode;
    logic [ACCESS_W-1:0] want_access;

    modport source (
        output valid, req_type, id_user, id_group, perm_mode, want_access,
        input  ready
    );

    modport sink (
        input  valid, req_type, id_user, id_group, perm_mode, want_access,
        output ready
    );

endinterface

>>> rtl/cred_rsp_if.sv
// ----------------------------------------------------------------------------
// cred_rsp_if
// response channel: valid/ready handshake with the ok flag
// ----------------------------------------------------------------------------
interface cred_rsp_if;

    logic valid;
    logic ready;
    logic ok;

    modport source (
        output valid, ok,
        input  ready
    );

    modport sink (
        input  valid, ok,
        output ready
    );

endinterface

>>> rtl/credential_set_and_permission_check.sv
// ----------------------------------------------------------------------------
// credential_set_and_permission_check
// keeps real, effective and saved user and group ids; applies set requests
// and answers file access checks, one ok flag per request
// ----------------------------------------------------------------------------
// usage
//   i_req carries one request per transfer: type, user id, group id, mode
//   bits and wanted access. o_rsp returns one ok flag per request, in order.
//   a request taken into the request register is decided there by the
//   core, and its result is registered in the response register, from
//   which the response is offered; a stalled o_rsp delays the decision.
//   throughput: one request per cycle while o_rsp is not stalled, set by
//   the single decision stage between the request and response registers,
//   which also updates the credentials so the next request sees them.
//   a stalled o_rsp holds the response; one more request is held in the
//   request register, after which i_req.ready drops until o_rsp drains.
//   reset (synchronous, active low) sets all six ids to 0 (root) and
//   empties both registers.
// ----------------------------------------------------------------------------
module credential_set_and_permission_check
    import cred_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    cred_req_if.sink   i_req,
    cred_rsp_if.source o_rsp
);

    logic r_in_valid;
    t_req r_in;
    logic r_out_valid;
    logic r_ok;

    logic proc_fire;
    logic in_fire;
    logic core_ok;

    assign proc_fire   = r_in_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = !r_in_valid || proc_fire;
    assign in_fire     = i_req.valid && i_req.ready;

    cred_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (proc_fire),
        .i_req   (r_in),
        .o_ok    (core_ok)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_in_valid <= 1'b1;
            end else if (proc_fire) begin
                r_in_valid <= 1'b0;
            end
            if (proc_fire) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in.req_type    <= i_req.req_type;
            r_in.id_user     <= i_req.id_user;
            r_in.id_group    <= i_req.id_group;
            r_in.perm_mode   <= i_req.perm_mode;
            r_in.want_access <= i_req.want_access;
        end
        if (proc_fire) begin
            r_ok <= core_ok;
        end
    end

    assign o_rsp.valid = r_out_valid;
    assign o_rsp.ok    = r_ok;

endmodule

>>> rtl/cred_core.sv
// ----------------------------------------------------------------------------
// cred_core
// credential registers, update rules and access decision for one request
// ----------------------------------------------------------------------------
module cred_core
    import cred_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_fire,
    input  t_req i_req,
    output logic o_ok
);

    logic [ID_W-1:0] r_real_user,  n_real_user;
    logic [ID_W-1:0] r_eff_user,   n_eff_user;
    logic [ID_W-1:0] r_saved_user, n_saved_user;
    logic [ID_W-1:0] r_real_group, n_real_group;
    logic [ID_W-1:0] r_eff_group,  n_eff_group;
    logic [ID_W-1:0] r_saved_group, n_saved_group;

    logic                priv;
    logic [ACCESS_W-1:0] triplet;
    logic                ok;

    assign priv = (r_eff_user == ROOT_ID);

    always_comb begin
        if (r_eff_user == i_req.id_user) begin
            triplet = i_req.perm_mode[MODE_OWNER_LSB +: ACCESS_W];
        end else if (r_eff_group == i_req.id_group) begin
            triplet = i_req.perm_mode[MODE_GROUP_LSB +: ACCESS_W];
        end else begin
            triplet = i_req.perm_mode[MODE_OTHER_LSB +: ACCESS_W];
        end
    end

    always_comb begin
        n_real_user   = r_real_user;
        n_eff_user    = r_eff_user;
        n_saved_user  = r_saved_user;
        n_real_group  = r_real_group;
        n_eff_group   = r_eff_group;
        n_saved_group = r_saved_group;
        ok            = 1'b0;
        unique case (i_req.req_type)
            REQ_INIT: begin
                n_real_user   = i_req.id_user;
                n_eff_user    = i_req.id_user;
                n_saved_user  = i_req.id_user;
                n_real_group  = i_req.id_group;
                n_eff_group   = i_req.id_group;
                n_saved_group = i_req.id_group;
                ok            = 1'b1;
            end
            REQ_SETUID: begin
                if (priv) begin
                    n_real_user  = i_req.id_user;
                    n_eff_user   = i_req.id_user;
                    n_saved_user = i_req.id_user;
                    ok           = 1'b1;
                end else if ((i_req.id_user == r_real_user) ||
                             (i_req.id_user == r_saved_user)) begin
                    n_eff_user = i_req.id_user;
                    ok         = 1'b1;
                end
            end
            REQ_SETEUID: begin
                if (priv || (i_req.id_user == r_real_user) ||
                    (i_req.id_user == r_eff_user) ||
                    (i_req.id_user == r_saved_user)) begin
                    n_eff_user = i_req.id_user;
                    ok         = 1'b1;
                end
            end
            REQ_SETGID: begin
                if (priv) begin
                    n_real_group  = i_req.id_user;
                    n_eff_group   = i_req.id_user;
                    n_saved_group = i_req.id_user;
                    ok            = 1'b1;
                end else if ((i_req.id_user == r_real_group) ||
                             (i_req.id_user == r_saved_group)) begin
                    n_eff_group = i_req.id_user;
                    ok          = 1'b1;
                end
            end
            REQ_SETEGID: begin
                if (priv || (i_req.id_user == r_real_group) ||
                    (i_req.id_user == r_eff_group) ||
                    (i_req.id_user == r_saved_group)) begin
                    n_eff_group = i_req.id_user;
                    ok          = 1'b1;
                end
            end
            REQ_CHECK: begin
                ok = priv || ((triplet & i_req.want_access) == i_req.want_access);
            end
            default: begin
                ok = 1'b0;
            end
        endcase
    end

    assign o_ok = ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_real_user   <= '0;
            r_eff_user    <= '0;
            r_saved_user  <= '0;
            r_real_group  <= '0;
            r_eff_group   <= '0;
            r_saved_group <= '0;
        end else if (i_fire) begin
            r_real_user   <= n_real_user;
            r_eff_user    <= n_eff_user;
            r_saved_user  <= n_saved_user;
            r_real_group  <= n_real_group;
            r_eff_group   <= n_eff_group;
            r_saved_group <= n_saved_group;
        end
    end

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// testbench for credential_set_and_permission_check: a tracker keeps its own
// copy of the six ids, predicts the ok flag of every request transfer and
// compares it with each response transfer, under random idling on both sides
// ----------------------------------------------------------------------------
module tb;
    import cred_pkg::*;

    localparam logic [REQ_W-1:0] REQ_UNUSED_LO = 3'd6;
    localparam logic [REQ_W-1:0] REQ_UNUSED_HI = 3'd7;
    localparam logic [ID_W-1:0]  ALL_ONES_ID   = '1;
    localparam int unsigned RANDOM_ITEMS  = 1550;
    localparam int unsigned QUIET_ITEMS   = 200;
    localparam int unsigned HOLD_AFTER    = 300;
    localparam int unsigned HOLD_CYCLES   = 150;
    localparam int unsigned DRAIN_CYCLES  = 4;
    localparam int unsigned IDLE_LIMIT    = 1000;

    class credential_tracker;
        logic [ID_W-1:0] real_user, eff_user, saved_user;
        logic [ID_W-1:0] real_group, eff_group, saved_group;
        bit              pending_grants[$];
        int unsigned     mismatches, checked, granted, refused;

        function new();
            real_user   = ROOT_ID;
            eff_user    = ROOT_ID;
            saved_user  = ROOT_ID;
            real_group  = ROOT_ID;
            eff_group   = ROOT_ID;
            saved_group = ROOT_ID;
            mismatches  = 0;
            checked     = 0;
            granted     = 0;
            refused     = 0;
        endfunction

        function bit decide_grant(t_req r);
            logic [ACCESS_W-1:0] triplet;
            bit                  privileged;
            bit                  ok;
            privileged = (eff_user == ROOT_ID);
            ok         = 1'b0;
            case (r.req_type)
                REQ_INIT: begin
                    real_user   = r.id_user;
                    eff_user    = r.id_user;
                    saved_user  = r.id_user;
                    real_group  = r.id_group;
                    eff_group   = r.id_group;
                    saved_group = r.id_group;
                    ok          = 1'b1;
                end
                REQ_SETUID: begin
                    if (privileged) begin
                        real_user  = r.id_user;
                        eff_user   = r.id_user;
                        saved_user = r.id_user;
                        ok         = 1'b1;
                    end else if (r.id_user == real_user || r.id_user == saved_user) begin
                        eff_user = r.id_user;
                        ok       = 1'b1;
                    end
                end
                REQ_SETEUID: begin
                    if (privileged || r.id_user == real_user || r.id_user == eff_user ||
                        r.id_user == saved_user) begin
                        eff_user = r.id_user;
                        ok       = 1'b1;
                    end
                end
                REQ_SETGID: begin
                    if (privileged) begin
                        real_group  = r.id_user;
                        eff_group   = r.id_user;
                        saved_group = r.id_user;
                        ok          = 1'b1;
                    end else if (r.id_user == real_group || r.id_user == saved_group) begin
                        eff_group = r.id_user;
                        ok        = 1'b1;
                    end
                end
                REQ_SETEGID: begin
                    if (privileged || r.id_user == real_group || r.id_user == eff_group ||
                        r.id_user == saved_group) begin
                        eff_group = r.id_user;
                        ok        = 1'b1;
                    end
                end
                REQ_CHECK: begin
                    if (privileged) begin
                        ok = 1'b1;
                    end else begin
                        if (eff_user == r.id_user)
                            triplet = r.perm_mode[MODE_OWNER_LSB +: ACCESS_W];
                        else if (eff_group == r.id_group)
                            triplet = r.perm_mode[MODE_GROUP_LSB +: ACCESS_W];
                        else
                            triplet = r.perm_mode[MODE_OTHER_LSB +: ACCESS_W];
                        ok = ((triplet & r.want_access) == r.want_access);
                    end
                end
                default: ok = 1'b0;
            endcase
            return ok;
        endfunction

        function void note_request(t_req r);
            bit ok;
            ok = decide_grant(r);
            pending_grants.push_back(ok);
            if (ok)
                granted++;
            else
                refused++;
        endfunction

        task report(string msg);
            $display("[%0t] mismatch: %s", $time, msg);
            mismatches++;
        endtask

        task check_grant(logic ok);
            bit want_ok;
            if (pending_grants.size() == 0) begin
                report("response transfer with no request outstanding");
            end else begin
                want_ok = pending_grants.pop_front();
                if (ok !== want_ok)
                    report($sformatf("ok is %b, predicted %b", ok, want_ok));
                checked++;
            end
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;
    bit   quiet;
    int unsigned sent;

    credential_tracker board = new();

    cred_req_if req_if();
    cred_rsp_if rsp_if();

    credential_set_and_permission_check DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic logic [ID_W-1:0] pick_id();
        case ($urandom_range(0, 9))
            0: return ROOT_ID;
            1: return ALL_ONES_ID;
            2, 3, 4, 5: begin
                case ($urandom_range(0, 5))
                    0: return board.real_user;
                    1: return board.eff_user;
                    2: return board.saved_user;
                    3: return board.real_group;
                    4: return board.eff_group;
                    default: return board.saved_group;
                endcase
            end
            6, 7: return ID_W'($urandom_range(1, 4));
            default: return $urandom;
        endcase
    endfunction

    task automatic send_request(input logic [REQ_W-1:0] kind, input logic [ID_W-1:0] uid,
                                input logic [ID_W-1:0] gid, input logic [MODE_W-1:0] mode,
                                input logic [ACCESS_W-1:0] want);
        t_req r;
        r.req_type    = kind;
        r.id_user     = uid;
        r.id_group    = gid;
        r.perm_mode   = mode;
        r.want_access = want;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        req_if.valid       <= 1'b1;
        req_if.req_type    <= r.req_type;
        req_if.id_user     <= r.id_user;
        req_if.id_group    <= r.id_group;
        req_if.perm_mode   <= r.perm_mode;
        req_if.want_access <= r.want_access;
        do @(posedge i_clk); while (!req_if.ready);
        board.note_request(r);
        sent++;
    endtask

    task automatic send_random();
        int unsigned         roll;
        logic [REQ_W-1:0]    kind;
        logic [ID_W-1:0]     uid;
        roll = $urandom_range(0, 99);
        uid  = pick_id();
        if (roll < 8) begin
            kind = REQ_INIT;
            if ($urandom_range(0, 3) == 0)
                uid = ROOT_ID;
        end else if (roll < 20) begin
            kind = REQ_SETUID;
        end else if (roll < 32) begin
            kind = REQ_SETEUID;
        end else if (roll < 44) begin
            kind = REQ_SETGID;
        end else if (roll < 56) begin
            kind = REQ_SETEGID;
        end else if (roll < 96) begin
            kind = REQ_CHECK;
        end else begin
            kind = $urandom_range(0, 1) ? REQ_UNUSED_HI : REQ_UNUSED_LO;
        end
        send_request(kind, uid, pick_id(), MODE_W'($urandom_range(0, 511)),
                     ACCESS_W'($urandom_range(0, 7)));
    endtask

    // response side: random stall bursts plus one long hold to back up the block
    initial begin
        int unsigned stall_left;
        bit          long_hold_done;
        stall_left     = 0;
        long_hold_done = 1'b0;
        rsp_if.ready   = 1'b0;
        forever begin
            @(posedge i_clk);
            if (rsp_if.valid && rsp_if.ready)
                board.check_grant(rsp_if.ok);
            if (stall_left == 0 && !quiet) begin
                if (!long_hold_done && board.checked >= HOLD_AFTER) begin
                    stall_left     = HOLD_CYCLES;
                    long_hold_done = 1'b1;
                end else if ($urandom_range(0, 9) == 0) begin
                    stall_left = $urandom_range(1, 12);
                end
            end
            rsp_if.ready <= (stall_left == 0) && i_rst_n;
            if (stall_left != 0)
                stall_left--;
        end
    end

    initial begin
        int unsigned idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
                idle = 0;
            else
                idle++;
        end
        $display("[%0t] no transfer for %0d cycles", $time, IDLE_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        int unsigned n;
        quiet              = 1'b0;
        sent               = 0;
        i_rst_n            = 1'b0;
        req_if.valid       = 1'b0;
        req_if.req_type    = REQ_INIT;
        req_if.id_user     = '0;
        req_if.id_group    = '0;
        req_if.perm_mode   = '0;
        req_if.want_access = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // root after reset, unused codes
        send_request(REQ_CHECK, 1000, 100, 9'o000, 3'd7);
        send_request(REQ_UNUSED_LO, ALL_ONES_ID, ALL_ONES_ID, 9'o777, 3'd7);
        send_request(REQ_UNUSED_HI, ROOT_ID, ROOT_ID, 9'o000, 3'd0);
        // unprivileged owner, group and other triplets, empty access
        send_request(REQ_INIT, 1000, 100, 9'o000, 3'd0);
        send_request(REQ_CHECK, 1000, 5, 9'o700, 3'd7);
        send_request(REQ_CHECK, 1000, 5, 9'o077, 3'd4);
        send_request(REQ_CHECK, 7, 100, 9'o070, 3'd7);
        send_request(REQ_CHECK, 7, 8, 9'o770, 3'd1);
        send_request(REQ_CHECK, 7, 8, 9'o000, 3'd0);
        // unprivileged id changes, refused and accepted
        send_request(REQ_SETUID, 5, 0, 9'o000, 3'd0);
        send_request(REQ_SETEUID, 5, 0, 9'o000, 3'd0);
        send_request(REQ_SETEUID, 1000, 0, 9'o000, 3'd0);
        send_request(REQ_SETGID, 7, 0, 9'o000, 3'd0);
        send_request(REQ_SETGID, 100, 0, 9'o000, 3'd0);
        send_request(REQ_SETEGID, 9, 0, 9'o000, 3'd0);
        send_request(REQ_SETEGID, 100, 0, 9'o000, 3'd0);
        // all-ones ids
        send_request(REQ_INIT, ALL_ONES_ID, ALL_ONES_ID, 9'o000, 3'd0);
        send_request(REQ_CHECK, ALL_ONES_ID, ALL_ONES_ID, 9'o777, 3'd7);
        send_request(REQ_SETUID, ROOT_ID, ROOT_ID, 9'o777, 3'd7);
        // root dropping privilege
        send_request(REQ_INIT, ROOT_ID, ALL_ONES_ID, 9'o000, 3'd0);
        send_request(REQ_SETGID, ALL_ONES_ID, 0, 9'o000, 3'd0);
        send_request(REQ_SETUID, ALL_ONES_ID, 0, 9'o000, 3'd0);
        send_request(REQ_SETEUID, ROOT_ID, 0, 9'o000, 3'd0);
        send_request(REQ_CHECK, ROOT_ID, ROOT_ID, 9'o007, 3'd7);
        send_request(REQ_INIT, ROOT_ID, ROOT_ID, 9'o000, 3'd0);

        for (n = 0; n < RANDOM_ITEMS; n++) begin
            quiet = (n >= RANDOM_ITEMS - QUIET_ITEMS);
            send_random();
        end
        req_if.valid <= 1'b0;

        while (board.pending_grants.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d requests of all six kinds and unused codes, root and unprivileged",
                 sent);
        $display("responses checked %0d: %0d granted, %0d refused", board.checked,
                 board.granted, board.refused);
        if (board.mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
